@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SCCR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SCCR_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define SCCR_ASSERT(name, clk, rst_n, prop)
`define SCCR_ASSERT_NR(name, clk, prop)
`endif
`endif

@@ hw/rtl/sccr_pkg.sv @@
// ---------------------------------------------------------------------------
// sccr_pkg
// Shared types and codes for the sector cache clock replacement engine.
// ---------------------------------------------------------------------------
`default_nettype none
package sccr_pkg;
    localparam int SLOT_W = 6;
    localparam int TAG_W  = 32;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    // update applied by the cell holding the token
    typedef struct packed {
        logic             wr_tag;
        logic [TAG_W-1:0] tag;
        logic             set_valid;
        logic             set_ref;
        logic             clr_ref;
        logic             set_dirty;
        logic             clr_dirty;
    } cell_ops_t;

    // cell contents, zero unless the cell holds the token
    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic             ref_bit;
        logic [TAG_W-1:0] tag;
    } cell_state_t;
endpackage
`default_nettype wire

@@ hw/rtl/sccr_cell.sv @@
// ---------------------------------------------------------------------------
// sccr_cell
// One cache slot: tag, flags and a scan token passed to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none
module sccr_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 tok_load_en,
    input  wire logic                 tok_load_bit,
    input  wire logic                 tok_shift,
    input  wire logic                 tok_in,
    output logic                      tok,
    input  wire sccr_pkg::cell_ops_t  ops,
    output sccr_pkg::cell_state_t     view,
    output logic                      dv
);
    logic                       valid_reg, valid_next;
    logic                       dirty_reg, dirty_next;
    logic                       ref_reg, ref_next;
    logic                       tok_reg, tok_next;
    logic [sccr_pkg::TAG_W-1:0] tag_reg, tag_next;

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        ref_next   = ref_reg;
        tag_next   = tag_reg;
        if (tok_reg)
        begin
            if (ops.set_valid) valid_next = 1'b1;
            if (ops.wr_tag)    tag_next   = ops.tag;
            if (ops.clr_ref)   ref_next   = 1'b0;
            if (ops.set_ref)   ref_next   = 1'b1;
            if (ops.clr_dirty) dirty_next = 1'b0;
            if (ops.set_dirty) dirty_next = 1'b1;
        end
        if (tok_load_en)
            tok_next = tok_load_bit;
        else if (tok_shift)
            tok_next = tok_in;
        else
            tok_next = tok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            ref_reg   <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            ref_reg   <= ref_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign tok          = tok_reg;
    assign dv           = valid_reg & dirty_reg;
    assign view.valid   = tok_reg & valid_reg;
    assign view.dirty   = tok_reg & dirty_reg;
    assign view.ref_bit = tok_reg & ref_reg;
    assign view.tag     = tok_reg ? tag_reg : '0;
endmodule
`default_nettype wire

@@ hw/rtl/sector_cache_clock_replacement_top.sv @@
// ---------------------------------------------------------------------------
// sector_cache_clock_replacement_top
// Tag lookup and clock (second-chance) replacement for a sector cache.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A token walks the
// row of slot cells one slot per cycle while it scans. Read/write: lookup
// scans slots from 0 and stops on the first match; a miss fills the first
// invalid slot or, with every slot valid, runs a clock sweep from the slot
// after the hand. Flush scans slots 0 up to the last dirty one, one slot per
// cycle, and issues one result as the token passes each dirty slot; a flush
// with nothing dirty, or an unused code, gives one result with only last set.
// Results appear on result_valid for one cycle and cannot be held off.
`default_nettype none
`include "assert_macros.svh"
module sector_cache_clock_replacement_top
#(
    parameter int SLOT_COUNT = 64
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  func,
    input  wire logic [sccr_pkg::TAG_W-1:0]  sector,
    output logic                             result_valid,
    output logic [sccr_pkg::SLOT_W-1:0]      slot,
    output logic                             hit,
    output logic                             fill,
    output logic                             writeback,
    output logic [sccr_pkg::TAG_W-1:0]       writeback_sector,
    output logic                             last
);
    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           free_reg, free_next;
    logic                       have_free_reg, have_free_next;
    logic [IDX_W-1:0]           hand_reg, hand_next;
    logic                       wr_reg, wr_next;
    logic [sccr_pkg::TAG_W-1:0] sector_reg, sector_next;

    logic                       rv_reg, rv_next;
    logic [IDX_W-1:0]           slot_reg, slot_next;
    logic                       hit_reg, hit_next;
    logic                       fill_reg, fill_next;
    logic                       wb_reg, wb_next;
    logic [sccr_pkg::TAG_W-1:0] wbs_reg, wbs_next;
    logic                       last_reg, last_next;

    logic                       tok_load_en;
    logic [IDX_W-1:0]           load_idx;
    logic                       tok_shift;
    sccr_pkg::cell_ops_t        ops;
    sccr_pkg::cell_state_t      views [SLOT_COUNT];
    sccr_pkg::cell_state_t      sel;
    logic [SLOT_COUNT-1:0]      tok_vec;
    logic [SLOT_COUNT-1:0]      dv_vec;
    logic                       dirty_later;
    logic [IDX_W-1:0]           idx_adv;
    logic [IDX_W-1:0]           hand_adv;

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++)
        begin : g_cell
            sccr_cell u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .tok_load_en  (tok_load_en),
                .tok_load_bit (load_idx == IDX_W'(g)),
                .tok_shift    (tok_shift),
                .tok_in       (tok_vec[(g + SLOT_COUNT - 1) % SLOT_COUNT]),
                .tok          (tok_vec[g]),
                .ops          (ops),
                .view         (views[g]),
                .dv           (dv_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        sel         = '0;
        dirty_later = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            sel = sel | views[i];
            if (IDX_W'(i) > idx_reg)
                dirty_later = dirty_later | dv_vec[i];
        end
    end

    assign idx_adv  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign hand_adv = (hand_reg == IDX_LAST) ? '0 : hand_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        free_next      = free_reg;
        have_free_next = have_free_reg;
        hand_next      = hand_reg;
        wr_next        = wr_reg;
        sector_next    = sector_reg;
        rv_next        = 1'b0;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        fill_next      = fill_reg;
        wb_next        = wb_reg;
        wbs_next       = wbs_reg;
        last_next      = last_reg;
        tok_load_en    = 1'b0;
        load_idx       = '0;
        tok_shift      = 1'b0;
        ops            = '0;
        ops.tag        = sector_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    wr_next     = (func == sccr_pkg::FUNC_WRITE);
                    sector_next = sector;
                    idx_next    = '0;
                    tok_load_en = 1'b1;
                    if (func == sccr_pkg::FUNC_READ || func == sccr_pkg::FUNC_WRITE)
                    begin
                        have_free_next = 1'b0;
                        state_next     = ST_LOOK;
                    end
                    else if (func == sccr_pkg::FUNC_FLUSH && (|dv_vec))
                        state_next = ST_FLUSH;
                    else
                    begin
                        // empty flush or unused code: one result, all zero but last
                        rv_next   = 1'b1;
                        slot_next = '0;
                        hit_next  = 1'b0;
                        fill_next = 1'b0;
                        wb_next   = 1'b0;
                        wbs_next  = '0;
                        last_next = 1'b1;
                    end
                end
            end
            ST_LOOK:
            begin
                if (sel.valid && sel.tag == sector_reg)
                begin
                    ops.set_ref   = 1'b1;
                    ops.set_dirty = wr_reg;
                    rv_next       = 1'b1;
                    slot_next     = idx_reg;
                    hit_next      = 1'b1;
                    fill_next     = 1'b0;
                    wb_next       = 1'b0;
                    wbs_next      = '0;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    if (!sel.valid && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_next      = idx_reg;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        tok_load_en = 1'b1;
                        if (have_free_reg || !sel.valid)
                        begin
                            load_idx   = have_free_reg ? free_reg : idx_reg;
                            idx_next   = load_idx;
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            load_idx   = hand_adv;
                            idx_next   = hand_adv;
                            state_next = ST_SWEEP;
                        end
                    end
                    else
                    begin
                        tok_shift = 1'b1;
                        idx_next  = idx_adv;
                    end
                end
            end
            ST_FILL:
            begin
                ops.set_valid = 1'b1;
                ops.wr_tag    = 1'b1;
                ops.set_ref   = 1'b1;
                ops.set_dirty = wr_reg;
                rv_next       = 1'b1;
                slot_next     = idx_reg;
                hit_next      = 1'b0;
                fill_next     = 1'b1;
                wb_next       = 1'b0;
                wbs_next      = '0;
                last_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (sel.ref_bit)
                begin
                    // second chance: clear and move on
                    ops.clr_ref = 1'b1;
                    tok_shift   = 1'b1;
                    idx_next    = idx_adv;
                end
                else
                begin
                    hand_next     = idx_reg;
                    ops.wr_tag    = 1'b1;
                    ops.set_ref   = 1'b1;
                    ops.clr_dirty = 1'b1;
                    ops.set_dirty = wr_reg;
                    rv_next       = 1'b1;
                    slot_next     = idx_reg;
                    hit_next      = 1'b0;
                    fill_next     = 1'b1;
                    wb_next       = sel.dirty;
                    wbs_next      = sel.dirty ? sel.tag : '0;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                tok_shift = 1'b1;
                idx_next  = idx_adv;
                if (sel.valid && sel.dirty)
                begin
                    ops.clr_dirty = 1'b1;
                    rv_next       = 1'b1;
                    slot_next     = idx_reg;
                    hit_next      = 1'b0;
                    fill_next     = 1'b0;
                    wb_next       = 1'b1;
                    wbs_next      = sel.tag;
                    last_next     = !dirty_later;
                    if (!dirty_later)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            free_reg      <= '0;
            have_free_reg <= 1'b0;
            hand_reg      <= '0;
            wr_reg        <= 1'b0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            free_reg      <= free_next;
            have_free_reg <= have_free_next;
            hand_reg      <= hand_next;
            wr_reg        <= wr_next;
            rv_reg        <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        slot_reg   <= slot_next;
        hit_reg    <= hit_next;
        fill_reg   <= fill_next;
        wb_reg     <= wb_next;
        wbs_reg    <= wbs_next;
        last_reg   <= last_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign result_valid     = rv_reg;
    assign slot             = (sccr_pkg::SLOT_W)'(slot_reg);
    assign hit              = hit_reg;
    assign fill             = fill_reg;
    assign writeback        = wb_reg;
    assign writeback_sector = wbs_reg;
    assign last             = last_reg;

    // finishing an item always coincides with its final transfer
    `SCCR_ASSERT(a_done_last, clk, rst_n, $fell(busy) |-> (result_valid && last))
    // a non-final transfer means the item is still being worked on
    `SCCR_ASSERT(a_more_busy, clk, rst_n, (result_valid && !last) |-> busy)
    // exactly one cell is examined while scanning
    `SCCR_ASSERT(a_tok_onehot, clk, rst_n, busy |-> $onehot(tok_vec))
    `SCCR_ASSERT_NR(a_rst_quiet, clk, !rst_n |-> !result_valid)
endmodule
`default_nettype wire
